FILE: src/mlq_pkg.sv
// Shared constants and types of the multi-list linked queue manager.
`default_nettype none

package mlq_pkg;

  // Field widths of a request and of a result.
  localparam int OP_W       = 2;
  localparam int LIST_SEL_W = 3;
  localparam int ENTRY_W    = 8;

  // Default sizing of the entry pool and of the list set.
  localparam int DEF_ENTRY_COUNT = 256;
  localparam int DEF_LIST_COUNT  = 5;

  // Operation codes carried in the op field.
  typedef enum logic [OP_W-1:0] {
    OP_ADD    = 2'd0,
    OP_POP    = 2'd1,
    OP_REMOVE = 2'd2,
    OP_QUERY  = 2'd3
  } op_e;

endpackage

`default_nettype wire

FILE: src/mlq_if.sv
// Request and result channel interfaces of the multi-list linked queue manager.
`default_nettype none

interface mlq_req_if;
  logic                           valid;
  logic                           ready;
  logic [mlq_pkg::OP_W-1:0]       op;
  logic [mlq_pkg::LIST_SEL_W-1:0] list_sel;
  logic [mlq_pkg::ENTRY_W-1:0]    entry;

  modport source (output valid, output op, output list_sel, output entry, input ready);
  modport sink   (input valid, input op, input list_sel, input entry, output ready);
endinterface

interface mlq_rsp_if;
  logic                        valid;
  logic                        ready;
  logic                        ok;
  logic [mlq_pkg::ENTRY_W-1:0] popped_entry;

  modport source (output valid, output ok, output popped_entry, input ready);
  modport sink   (input valid, input ok, input popped_entry, output ready);
endinterface

`default_nettype wire

FILE: src/mlq_ram.sv
// Simple dual-port synchronous RAM with one write port and one registered read port.
`default_nettype none

module mlq_ram #(
  parameter int DEPTH = 4,
  parameter int WIDTH = 1,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [0:DEPTH-1];
  logic [WIDTH-1:0] rdata_q;

  // Write port and registered read port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

FILE: src/multi_list_linked_queue_manager.sv
// Top level of the multi-list linked queue manager: control, list heads and link RAMs.
//
//   channel   direction   handshake       payload
//   req_i     in          valid / ready   op, list_sel, entry
//   rsp_o     out         valid / ready   ok, popped_entry
//
// A query, a pop of an empty list, or a request for a list or entry out of range finishes
// in the cycle it is accepted. A pop, an add to an empty list, a remove of the head and an
// add or remove with nothing to do finish in ST_READ after the link read; an add to a non-empty
// list and a remove with a predecessor go on to ST_LINK, as the next-link RAM has a single write
// port. After reset, clearing all LIST_COUNT * ENTRY_COUNT cells (1280 by default) holds
// req_i.ready low. A result waits in the output register; if it is still full, the block holds.
`default_nettype none

module multi_list_linked_queue_manager #(
  parameter int ENTRY_COUNT = mlq_pkg::DEF_ENTRY_COUNT,
  parameter int LIST_COUNT  = mlq_pkg::DEF_LIST_COUNT
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  mlq_req_if.sink    req_i,
  mlq_rsp_if.source  rsp_o
);

  import mlq_pkg::*;

  localparam int CELL_COUNT = LIST_COUNT * ENTRY_COUNT;
  localparam int CELL_W     = $clog2(CELL_COUNT);
  localparam int EIDX_W     = $clog2(ENTRY_COUNT);
  localparam int LINK_W     = $clog2(ENTRY_COUNT + 1);
  localparam int LIDX_W     = (LIST_COUNT > 1) ? $clog2(LIST_COUNT) : 1;
  localparam int A_W        = LINK_W + 1;

  localparam logic [LINK_W-1:0] NIL_LINK  = LINK_W'(ENTRY_COUNT);
  localparam logic [CELL_W-1:0] LAST_CELL = CELL_W'(CELL_COUNT - 1);

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_LINK,
    ST_RESP
  } state_e;

  // Cell address of one (list, entry) pair.
  function automatic logic [CELL_W-1:0] cell_addr(input logic [LIDX_W-1:0] l,
                                                  input logic [EIDX_W-1:0] e);
    return CELL_W'(32'(l) * ENTRY_COUNT + 32'(e));
  endfunction

  state_e state_q, state_d;
  op_e    op_q, op_d;

  logic [LIDX_W-1:0] lst_q, lst_d;
  logic [EIDX_W-1:0] ent_q, ent_d;
  logic [EIDX_W-1:0] head_q [0:LIST_COUNT-1];
  logic [EIDX_W-1:0] head_d [0:LIST_COUNT-1];
  logic [EIDX_W-1:0] tail_q [0:LIST_COUNT-1];
  logic [EIDX_W-1:0] tail_d [0:LIST_COUNT-1];
  logic [LIST_COUNT-1:0] nonempty_q, nonempty_d;
  logic [CELL_W-1:0] link_cell_q, link_cell_d;
  logic [LINK_W-1:0] link_val_q, link_val_d;
  logic [CELL_W-1:0] clr_cnt_q, clr_cnt_d;
  logic              res_ok_q, res_ok_d;
  logic [ENTRY_W-1:0] res_pop_q, res_pop_d;
  logic              out_valid_q, out_valid_d;
  logic              out_ok_q, out_ok_d;
  logic [ENTRY_W-1:0] out_pop_q, out_pop_d;

  // RAM ports: A holds {member, next}, B holds prev.
  logic              a_we, b_we;
  logic [CELL_W-1:0] a_waddr, b_waddr, ram_raddr;
  logic [A_W-1:0]    a_wdata, a_rdata;
  logic [LINK_W-1:0] b_wdata, b_rdata;

  // Request decode.
  logic              list_ok, entry_ok;
  logic [LIDX_W-1:0] req_lidx;
  logic [EIDX_W-1:0] req_eidx;
  op_e               req_op;

  // Links read for the current cell.
  logic              rd_member, has_next, has_prev;
  logic [LINK_W-1:0] rd_next, rd_prev;
  logic [CELL_W-1:0] cur_cell;

  // Result of the finishing step.
  logic              fin;
  logic              fin_ok;
  logic [ENTRY_W-1:0] fin_pop;
  logic [ENTRY_W-1:0] done_pop;

  assign list_ok  = 32'(req_i.list_sel) < LIST_COUNT;
  assign entry_ok = 32'(req_i.entry) < ENTRY_COUNT;
  assign req_lidx = LIDX_W'(req_i.list_sel);
  assign req_op   = op_e'(req_i.op);
  assign req_eidx = (req_op == OP_POP) ? head_q[req_lidx] : EIDX_W'(req_i.entry);

  // The RAMs read at the incoming request's cell on the edge that accepts it.
  assign ram_raddr = cell_addr(req_lidx, req_eidx);

  assign rd_member = a_rdata[LINK_W];
  assign rd_next   = a_rdata[LINK_W-1:0];
  assign rd_prev   = b_rdata;
  assign has_next  = rd_next < NIL_LINK;
  assign has_prev  = rd_prev < NIL_LINK;
  assign cur_cell  = cell_addr(lst_q, ent_q);
  assign done_pop  = (op_q == OP_POP) ? ENTRY_W'(ent_q) : '0;

  mlq_ram #(
    .DEPTH (CELL_COUNT),
    .WIDTH (A_W)
  ) u_next_ram (
    .clk_i   (clk_i),
    .we_i    (a_we),
    .waddr_i (a_waddr),
    .wdata_i (a_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (a_rdata)
  );

  mlq_ram #(
    .DEPTH (CELL_COUNT),
    .WIDTH (LINK_W)
  ) u_prev_ram (
    .clk_i   (clk_i),
    .we_i    (b_we),
    .waddr_i (b_waddr),
    .wdata_i (b_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (b_rdata)
  );

  // Sequencer: decode, read the links, write them back and hand over the result.
  always_comb begin
    state_d     = state_q;
    op_d        = op_q;
    lst_d       = lst_q;
    ent_d       = ent_q;
    head_d      = head_q;
    tail_d      = tail_q;
    nonempty_d  = nonempty_q;
    link_cell_d = link_cell_q;
    link_val_d  = link_val_q;
    clr_cnt_d   = clr_cnt_q;
    res_ok_d    = res_ok_q;
    res_pop_d   = res_pop_q;
    out_valid_d = out_valid_q && !rsp_o.ready;
    out_ok_d    = out_ok_q;
    out_pop_d   = out_pop_q;
    a_we        = 1'b0;
    a_waddr     = cur_cell;
    a_wdata     = '0;
    b_we        = 1'b0;
    b_waddr     = cur_cell;
    b_wdata     = '0;
    fin         = 1'b0;
    fin_ok      = 1'b0;
    fin_pop     = '0;

    case (state_q)
      ST_CLEAR: begin
        a_we    = 1'b1;
        a_waddr = clr_cnt_q;
        if (clr_cnt_q == LAST_CELL) begin
          state_d = ST_IDLE;
        end else begin
          clr_cnt_d = clr_cnt_q + 1'b1;
        end
      end

      ST_IDLE: begin
        if (req_i.valid) begin
          op_d  = req_op;
          lst_d = req_lidx;
          ent_d = req_eidx;
          if (!list_ok) begin
            fin = 1'b1;
          end else begin
            case (req_op)
              OP_ADD, OP_REMOVE: begin
                if (entry_ok) begin
                  state_d = ST_READ;
                end else begin
                  fin = 1'b1;
                end
              end
              OP_POP: begin
                if (nonempty_q[req_lidx]) begin
                  state_d = ST_READ;
                end else begin
                  fin = 1'b1;
                end
              end
              default: begin
                fin    = 1'b1;
                fin_ok = nonempty_q[req_lidx];
              end
            endcase
          end
        end
      end

      ST_READ: begin
        if (op_q == OP_ADD) begin
          if (rd_member) begin
            fin = 1'b1;
          end else begin
            // Append at the tail: the new cell points back to the old tail.
            a_we    = 1'b1;
            a_wdata = {1'b1, NIL_LINK};
            b_we    = 1'b1;
            b_wdata = nonempty_q[lst_q] ? LINK_W'(tail_q[lst_q]) : NIL_LINK;
            tail_d[lst_q] = ent_q;
            if (nonempty_q[lst_q]) begin
              link_cell_d = cell_addr(lst_q, tail_q[lst_q]);
              link_val_d  = LINK_W'(ent_q);
              state_d     = ST_LINK;
            end else begin
              head_d[lst_q]     = ent_q;
              nonempty_d[lst_q] = 1'b1;
              fin               = 1'b1;
              fin_ok            = 1'b1;
            end
          end
        end else begin
          if (!rd_member) begin
            fin = 1'b1;
          end else begin
            // Unlink: clear membership and patch the successor's back link.
            a_we    = 1'b1;
            a_wdata = {1'b0, rd_next};
            if (has_next) begin
              b_we    = 1'b1;
              b_waddr = cell_addr(lst_q, EIDX_W'(rd_next));
              b_wdata = rd_prev;
            end
            if (!has_prev && has_next) begin
              head_d[lst_q] = EIDX_W'(rd_next);
            end
            if (!has_next && has_prev) begin
              tail_d[lst_q] = EIDX_W'(rd_prev);
            end
            if (!has_prev && !has_next) begin
              nonempty_d[lst_q] = 1'b0;
            end
            if (has_prev) begin
              link_cell_d = cell_addr(lst_q, EIDX_W'(rd_prev));
              link_val_d  = rd_next;
              state_d     = ST_LINK;
            end else begin
              fin     = 1'b1;
              fin_ok  = 1'b1;
              fin_pop = done_pop;
            end
          end
        end
      end

      ST_LINK: begin
        // Forward link of the predecessor, which is a member by construction.
        a_we    = 1'b1;
        a_waddr = link_cell_q;
        a_wdata = {1'b1, link_val_q};
        fin     = 1'b1;
        fin_ok  = 1'b1;
        fin_pop = done_pop;
      end

      ST_RESP: begin
        fin     = 1'b1;
        fin_ok  = res_ok_q;
        fin_pop = res_pop_q;
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase

    // Hand the result to the output register, or hold it until that frees up.
    if (fin) begin
      if (!out_valid_q || rsp_o.ready) begin
        out_valid_d = 1'b1;
        out_ok_d    = fin_ok;
        out_pop_d   = fin_pop;
        state_d     = ST_IDLE;
      end else begin
        res_ok_d  = fin_ok;
        res_pop_d = fin_pop;
        state_d   = ST_RESP;
      end
    end
  end

  // State and registered outputs.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      op_q        <= OP_ADD;
      lst_q       <= '0;
      ent_q       <= '0;
      head_q      <= '{default: '0};
      tail_q      <= '{default: '0};
      nonempty_q  <= '0;
      link_cell_q <= '0;
      link_val_q  <= '0;
      clr_cnt_q   <= '0;
      res_ok_q    <= 1'b0;
      res_pop_q   <= '0;
      out_valid_q <= 1'b0;
      out_ok_q    <= 1'b0;
      out_pop_q   <= '0;
    end else begin
      state_q     <= state_d;
      op_q        <= op_d;
      lst_q       <= lst_d;
      ent_q       <= ent_d;
      head_q      <= head_d;
      tail_q      <= tail_d;
      nonempty_q  <= nonempty_d;
      link_cell_q <= link_cell_d;
      link_val_q  <= link_val_d;
      clr_cnt_q   <= clr_cnt_d;
      res_ok_q    <= res_ok_d;
      res_pop_q   <= res_pop_d;
      out_valid_q <= out_valid_d;
      out_ok_q    <= out_ok_d;
      out_pop_q   <= out_pop_d;
    end
  end

  assign req_i.ready        = (state_q == ST_IDLE);
  assign rsp_o.valid        = out_valid_q;
  assign rsp_o.ok           = out_ok_q;
  assign rsp_o.popped_entry = out_pop_q;

endmodule

`default_nettype wire

FILE: verif/multi_list_linked_queue_manager_tb.sv
// Self-checking testbench of the multi-list linked queue manager with its own list predictor.
`timescale 1ns / 1ps

module multi_list_linked_queue_manager_tb;
  import mlq_pkg::*;

  localparam int ENTRIES = DEF_ENTRY_COUNT;
  localparam int LISTS = DEF_LIST_COUNT;
  localparam logic [ENTRY_W:0] NO_LINK = (ENTRY_W + 1)'(ENTRIES);
  localparam int WATCHDOG_LIMIT = 20000;
  localparam int MAX_PRINTED = 100;

  typedef struct packed {
    logic               ok;
    logic [ENTRY_W-1:0] popped_entry;
  } list_result_t;

  // Shadow copy of every list plus the queue of results still to come back.
  class list_scoreboard;
    bit                 in_list [LISTS][ENTRIES];
    logic [ENTRY_W:0]   next_of [LISTS][ENTRIES];
    logic [ENTRY_W:0]   prev_of [LISTS][ENTRIES];
    logic [ENTRY_W-1:0] head_of [LISTS];
    logic [ENTRY_W-1:0] tail_of [LISTS];
    bit                 filled  [LISTS];
    list_result_t       awaited_results [$];
    int                 mismatches;

    // Takes one entry out of a list and patches its neighbors, head and tail.
    function void unlink_entry(int lst, logic [ENTRY_W-1:0] ent);
      logic [ENTRY_W:0] nx;
      logic [ENTRY_W:0] pv;
      nx = next_of[lst][ent];
      pv = prev_of[lst][ent];
      in_list[lst][ent] = 1'b0;
      if (pv != NO_LINK) begin
        next_of[lst][pv[ENTRY_W-1:0]] = nx;
      end else if (nx != NO_LINK) begin
        head_of[lst] = nx[ENTRY_W-1:0];
      end
      if (nx != NO_LINK) begin
        prev_of[lst][nx[ENTRY_W-1:0]] = pv;
      end else if (pv != NO_LINK) begin
        tail_of[lst] = pv[ENTRY_W-1:0];
      end
      if (pv == NO_LINK && nx == NO_LINK) filled[lst] = 1'b0;
    endfunction

    // Applies one list operation to the shadow state and returns its result.
    function list_result_t predict_list_op(op_e op, logic [LIST_SEL_W-1:0] lst_sel,
                                           logic [ENTRY_W-1:0] ent);
      list_result_t res;
      int           lst;
      res = '0;
      lst = int'(lst_sel);
      if (lst < LISTS) begin
        case (op)
          OP_ADD: begin
            if (!in_list[lst][ent]) begin
              next_of[lst][ent] = NO_LINK;
              if (filled[lst]) begin
                prev_of[lst][ent] = {1'b0, tail_of[lst]};
                next_of[lst][tail_of[lst]] = {1'b0, ent};
              end else begin
                prev_of[lst][ent] = NO_LINK;
                head_of[lst] = ent;
                filled[lst] = 1'b1;
              end
              tail_of[lst] = ent;
              in_list[lst][ent] = 1'b1;
              res.ok = 1'b1;
            end
          end
          OP_POP: begin
            if (filled[lst]) begin
              res.popped_entry = head_of[lst];
              unlink_entry(lst, head_of[lst]);
              res.ok = 1'b1;
            end
          end
          OP_REMOVE: begin
            if (in_list[lst][ent]) begin
              unlink_entry(lst, ent);
              res.ok = 1'b1;
            end
          end
          default: begin
            res.ok = filled[lst];
          end
        endcase
      end
      return res;
    endfunction

    task note_request(op_e op, logic [LIST_SEL_W-1:0] lst_sel, logic [ENTRY_W-1:0] ent);
      awaited_results.push_back(predict_list_op(op, lst_sel, ent));
    endtask

    task report_mismatch(string msg);
      mismatches++;
      if (mismatches <= MAX_PRINTED) $display("%0t ns: %s", $time, msg);
    endtask

    task check_result(logic ok, logic [ENTRY_W-1:0] popped);
      list_result_t exp;
      if (awaited_results.size() == 0) begin
        report_mismatch($sformatf("unexpected result ok=%0b popped_entry=%0d", ok, popped));
        return;
      end
      exp = awaited_results.pop_front();
      if (ok !== exp.ok)
        report_mismatch($sformatf("ok: expected %0b, got %0b", exp.ok, ok));
      if (popped !== exp.popped_entry)
        report_mismatch($sformatf("popped_entry: expected %0d, got %0d",
                                  exp.popped_entry, popped));
    endtask

    function int pending();
      return awaited_results.size();
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;
  bit   idle_on = 1'b1;
  int   idle_cycles = 0;
  list_scoreboard sb;

  mlq_req_if req_if ();
  mlq_rsp_if rsp_if ();

  multi_list_linked_queue_manager u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if),
    .rsp_o  (rsp_if)
  );

  // Free-running clock.
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Issues one request and holds it until the block takes it.
  task automatic send_request(op_e op, logic [LIST_SEL_W-1:0] lst, logic [ENTRY_W-1:0] ent);
    req_if.valid    <= 1'b1;
    req_if.op       <= op;
    req_if.list_sel <= lst;
    req_if.entry    <= ent;
    do @(posedge clk_i); while (!req_if.ready);
  endtask

  // Holds requests back until every outstanding result has come out.
  task automatic drain_results();
    req_if.valid <= 1'b0;
    do @(posedge clk_i); while (sb.pending() != 0);
  endtask

  // Random request; the mode leans toward growing (1) or shrinking (2) the lists.
  task automatic random_request(int mode);
    int   roll;
    int   add_pct;
    int   pop_pct;
    int   rem_pct;
    op_e  op;
    logic [LIST_SEL_W-1:0] lst;
    logic [ENTRY_W-1:0]    ent;
    add_pct = (mode == 1) ? 60 : (mode == 2) ? 15 : 35;
    pop_pct = (mode == 1) ? 10 : (mode == 2) ? 45 : 25;
    rem_pct = (mode == 1) ? 20 : 30;
    roll = $urandom_range(0, 99);
    if (roll < add_pct) op = OP_ADD;
    else if (roll < add_pct + pop_pct) op = OP_POP;
    else if (roll < add_pct + pop_pct + rem_pct) op = OP_REMOVE;
    else op = OP_QUERY;
    lst = ($urandom_range(0, 9) == 0) ? LIST_SEL_W'($urandom_range(LISTS, 7))
                                      : LIST_SEL_W'($urandom_range(0, LISTS - 1));
    // A narrow entry range keeps adds and removes hitting existing members.
    ent = ($urandom_range(0, 3) == 0) ? ENTRY_W'($urandom_range(0, 255))
                                      : ENTRY_W'($urandom_range(0, 23));
    if (idle_on && $urandom_range(0, 5) == 0) begin
      req_if.valid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk_i);
    end
    send_request(op, lst, ent);
  endtask

  // Result side: ready with random stall bursts.
  initial begin
    rsp_if.ready <= 1'b0;
    @(posedge clk_i);
    forever begin
      if (idle_on && $urandom_range(0, 4) == 0) begin
        rsp_if.ready <= 1'b0;
        repeat ($urandom_range(1, 15)) @(posedge clk_i);
      end
      rsp_if.ready <= 1'b1;
      repeat ($urandom_range(1, 12)) @(posedge clk_i);
    end
  end

  // Watches both channels and feeds the scoreboard.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (req_if.valid && req_if.ready)
        sb.note_request(op_e'(req_if.op), req_if.list_sel, req_if.entry);
      if (rsp_if.valid && rsp_if.ready)
        sb.check_result(rsp_if.ok, rsp_if.popped_entry);
    end
    if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
  end

  // Ends a hung run.
  initial begin
    while (idle_cycles < WATCHDOG_LIMIT) @(posedge clk_i);
    $display("timeout: no handshake for %0d cycles", WATCHDOG_LIMIT);
    $display("end of test: mismatches");
    $finish;
  end

  // Main sequence: reset, directed corner cases, then random phases.
  initial begin
    int mode;
    sb = new;
    req_if.valid    <= 1'b0;
    req_if.op       <= OP_ADD;
    req_if.list_sel <= '0;
    req_if.entry    <= '0;
    rst_ni          <= 1'b0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Empty list behavior, duplicate add, out-of-range lists.
    send_request(OP_QUERY, 0, 0);
    send_request(OP_POP, 0, 0);
    send_request(OP_REMOVE, 0, 0);
    send_request(OP_ADD, 0, 0);
    send_request(OP_ADD, 0, 255);
    send_request(OP_ADD, 0, 0);
    send_request(OP_ADD, 4, 128);
    send_request(OP_ADD, 4, 255);
    send_request(OP_QUERY, 0, 0);
    send_request(OP_QUERY, 7, 0);
    send_request(OP_ADD, 5, 3);
    send_request(OP_POP, 6, 0);
    send_request(OP_REMOVE, 7, 255);
    // Removal of the tail, of a middle entry and of the head; pops down to empty.
    send_request(OP_REMOVE, 0, 255);
    send_request(OP_ADD, 0, 17);
    send_request(OP_ADD, 0, 42);
    send_request(OP_REMOVE, 0, 17);
    send_request(OP_POP, 0, 0);
    send_request(OP_POP, 0, 0);
    send_request(OP_POP, 0, 0);
    send_request(OP_QUERY, 0, 0);
    send_request(OP_REMOVE, 4, 128);
    send_request(OP_REMOVE, 4, 255);
    send_request(OP_QUERY, 4, 0);
    drain_results();

    // Random phases; the last two run without any stalls.
    for (int blk = 0; blk < 16; blk++) begin
      idle_on = (blk < 14) && ($urandom_range(0, 3) != 0);
      mode = $urandom_range(0, 2);
      for (int n = 0; n < 100; n++) random_request(mode);
      if (blk % 5 == 4) drain_results();
    end

    drain_results();
    repeat (20) @(posedge clk_i);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

FILE: sim.f
src/mlq_pkg.sv
src/mlq_if.sv
src/mlq_ram.sv
src/multi_list_linked_queue_manager.sv
verif/multi_list_linked_queue_manager_tb.sv
